// ----- src/srd_pkg.sv -----
// Shared types and constants of the sprite RLE row decoder.
package srd_pkg;

  localparam int unsigned COL_W   = 11;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned RGB_W   = 24;
  localparam int unsigned LIT_W   = 7;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Widest row the decoder supports; a larger frame_width acts as this.
  localparam int unsigned MAX_WIDTH = 1024;
  localparam int unsigned COL_MAX   = (1 << COL_W) - 1;
  localparam logic [COL_W-1:0] WIDTH_CAP =
    COL_W'((MAX_WIDTH > COL_MAX) ? COL_MAX : MAX_WIDTH);

  localparam logic [COL_W-1:0] WIDTH_RESET = COL_W'(1024);

  localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_ROW  = 2'd1,
    OP_DATA = 2'd2,
    OP_NONE = 2'd3
  } opcode_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_MODE  = 1'd0,
    REG_FRAME_WIDTH = 1'd1
  } cfg_reg_e;

  // One queued job for the back end: a palette write or a run to emit.
  typedef struct packed {
    logic             is_load;
    logic [IDX_W-1:0] idx;
    logic [RGB_W-1:0] rgb;
    logic             opaque;
    logic [COL_W-1:0] start_column;
    logic [COL_W-1:0] run_length;
    logic             end_of_row;
    logic             overflow;
  } job_t;

endpackage

// ----- src/srd_in_if.sv -----
// Input channel of the sprite RLE row decoder.
interface srd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [7:0]  palette_index;
  logic [7:0]  palette_red;
  logic [7:0]  palette_green;
  logic [7:0]  palette_blue;
  logic [10:0] row_indent;
  logic [7:0]  data_byte;

  modport source (
    output valid, opcode, palette_index, palette_red, palette_green, palette_blue,
           row_indent, data_byte,
    input  ready
  );
  modport sink (
    input  valid, opcode, palette_index, palette_red, palette_green, palette_blue,
           row_indent, data_byte,
    output ready
  );
endinterface

// ----- src/srd_out_if.sv -----
// Output channel of the sprite RLE row decoder.
interface srd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [10:0] start_column;
  logic [10:0] run_length;
  logic        end_of_row;
  logic        overflow;

  modport source (
    output valid, red, green, blue, alpha, start_column, run_length, end_of_row, overflow,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, alpha, start_column, run_length, end_of_row, overflow,
    output ready
  );
endinterface

// ----- src/srd_front.sv -----
// Front end: accepts items, tracks row state, clips runs and queues jobs.
module srd_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  srd_in_if.sink                    in_i,
  input  logic                      frame_mode_i,
  input  logic [srd_pkg::COL_W-1:0] frame_width_i,
  input  logic                      full_i,
  output logic                      push_o,
  output srd_pkg::job_t             job_o
);

  logic [srd_pkg::COL_W-1:0] column_q, column_d;
  logic [srd_pkg::LIT_W-1:0] literal_left_q, literal_left_d;
  logic                      in_row_q, in_row_d;

  logic                      accept;
  logic                      want_push;
  logic                      do_run;
  logic                      is_row;
  logic [srd_pkg::COL_W-1:0] eff_width;
  logic [srd_pkg::COL_W-1:0] col_base;
  logic [srd_pkg::COL_W-1:0] room;
  logic [srd_pkg::COL_W-1:0] run_n;
  logic [srd_pkg::COL_W-1:0] run_len;
  logic                      clipped;
  srd_pkg::opcode_e          op;

  assign op        = srd_pkg::opcode_e'(in_i.opcode);
  assign in_i.ready = !full_i;
  assign accept    = in_i.valid && !full_i;

  assign eff_width = (frame_width_i > srd_pkg::WIDTH_CAP) ? srd_pkg::WIDTH_CAP
                                                          : frame_width_i;
  assign is_row    = (op == srd_pkg::OP_ROW);
  assign col_base  = is_row ? '0 : column_q;
  assign room      = (eff_width > col_base) ? (eff_width - col_base) : '0;
  assign clipped   = (run_n > room);
  assign run_len   = clipped ? room : run_n;

  always_comb begin
    do_run         = 1'b0;
    want_push      = 1'b0;
    run_n          = '0;
    literal_left_d = literal_left_q;
    in_row_d       = in_row_q;
    job_o          = '0;
    job_o.idx      = in_i.data_byte;

    unique case (op)
      srd_pkg::OP_LOAD: begin
        want_push    = 1'b1;
        job_o.is_load = 1'b1;
        job_o.idx    = in_i.palette_index;
        job_o.rgb    = {in_i.palette_red, in_i.palette_green, in_i.palette_blue};
      end
      srd_pkg::OP_ROW: begin
        in_row_d       = 1'b1;
        literal_left_d = '0;
        run_n          = in_i.row_indent;
        do_run         = 1'b1;
      end
      srd_pkg::OP_DATA: begin
        if (in_row_q) begin
          if (literal_left_q != '0) begin
            literal_left_d = literal_left_q - 1'b1;
            run_n          = srd_pkg::COL_W'(1);
            job_o.opaque   = 1'b1;
            do_run         = 1'b1;
          end else if (in_i.data_byte == '0) begin
            // end of row: pad to the width
            in_row_d         = 1'b0;
            run_n            = room;
            job_o.end_of_row = 1'b1;
            do_run           = 1'b1;
          end else if (in_i.data_byte[7]) begin
            // transparent skip of byte - 0x80
            run_n  = srd_pkg::COL_W'(in_i.data_byte[6:0]);
            do_run = 1'b1;
          end else if (!frame_mode_i) begin
            literal_left_d = in_i.data_byte[6:0];
          end else begin
            run_n        = srd_pkg::COL_W'(1);
            job_o.opaque = 1'b1;
            do_run       = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase

    if (do_run) begin
      want_push          = 1'b1;
      job_o.start_column = col_base;
      job_o.run_length   = run_len;
      job_o.overflow     = clipped;
    end
  end

  assign column_d = do_run ? (col_base + run_len) : column_q;
  assign push_o   = accept && want_push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q       <= '0;
      literal_left_q <= '0;
      in_row_q       <= 1'b0;
    end else if (accept) begin
      column_q       <= column_d;
      literal_left_q <= literal_left_d;
      in_row_q       <= in_row_d;
    end
  end

endmodule

// ----- src/srd_queue.sv -----
// Two-entry job queue between the front and back ends.
module srd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  srd_pkg::job_t push_job_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          head_valid_o,
  output srd_pkg::job_t head_o
);

  srd_pkg::job_t entries_q [2];
  logic          wr_ptr_q;
  logic          rd_ptr_q;
  logic [1:0]    count_q, count_d;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = entries_q[rd_ptr_q];

  always_comb begin
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 2'd1;
      2'b01:   count_d = count_q - 2'd1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      count_q <= count_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

endmodule

// ----- src/srd_back.sv -----
// Back end: palette memory, color lookup and the output register.
module srd_back #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          head_valid_i,
  input  srd_pkg::job_t head_i,
  output logic          pop_o,
  srd_out_if.source     out_o
);

  localparam int unsigned AW = $clog2(PALETTE_DEPTH);

  logic [srd_pkg::RGB_W-1:0] palette_q [PALETTE_DEPTH];
  logic [srd_pkg::RGB_W-1:0] rdata_q;

  logic                      out_valid_q;
  logic                      opaque_q;
  logic                      idx_ok_q;
  logic [srd_pkg::COL_W-1:0] start_column_q;
  logic [srd_pkg::COL_W-1:0] run_length_q;
  logic                      end_of_row_q;
  logic                      overflow_q;

  logic          idx_ok;
  logic [AW-1:0] addr;
  logic          load_out;

  assign idx_ok   = (32'(head_i.idx) < PALETTE_DEPTH);
  assign addr     = head_i.idx[AW-1:0];
  assign pop_o    = head_valid_i && (head_i.is_load || !out_valid_q || out_o.ready);
  assign load_out = pop_o && !head_i.is_load;

  always_ff @(posedge clk_i) begin
    if (pop_o && head_i.is_load && idx_ok) begin
      palette_q[addr] <= head_i.rgb;
    end
    if (load_out) begin
      rdata_q <= palette_q[addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      opaque_q       <= head_i.opaque;
      idx_ok_q       <= idx_ok;
      start_column_q <= head_i.start_column;
      run_length_q   <= head_i.run_length;
      end_of_row_q   <= head_i.end_of_row;
      overflow_q     <= head_i.overflow;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic [srd_pkg::RGB_W-1:0] color;
  assign color = (opaque_q && idx_ok_q) ? rdata_q : '0;

  assign out_o.valid        = out_valid_q;
  assign out_o.red          = color[23:16];
  assign out_o.green        = color[15:8];
  assign out_o.blue         = color[7:0];
  assign out_o.alpha        = opaque_q ? srd_pkg::ALPHA_OPAQUE : '0;
  assign out_o.start_column = start_column_q;
  assign out_o.run_length   = run_length_q;
  assign out_o.end_of_row   = end_of_row_q;
  assign out_o.overflow     = overflow_q;

endmodule

// ----- src/sprite_rle_row_decoder_top.sv -----
// Top level of the sprite RLE row decoder.
// Decodes run-length coded palettized sprite rows into pixel runs. Input
// transactions load palette entries, open rows (emitting the indent as a
// transparent run) or carry coded bytes; each produces at most one output run
// transaction. The block takes one input transaction per cycle while the
// queue is not full and delivers one run per cycle while the output is ready;
// a run passes through the job queue, then the output register that holds the
// palette read. Throughput is set by the front end's column update, which
// clips each run against the frame width combinationally, and by the single
// read/write port of the palette memory in the back end. A two-entry queue
// lets the front keep accepting while a finished run waits on the output. The
// user must write frame_mode and frame_width only while idle; not enforced.
module sprite_rle_row_decoder_top #(
  parameter int unsigned PALETTE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [srd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [srd_pkg::COL_W-1:0]     cfg_wdata_i,
  srd_in_if.sink                        in_i,
  srd_out_if.source                     out_o
);

  // Configuration registers.
  logic                      frame_mode_q;
  logic [srd_pkg::COL_W-1:0] frame_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_mode_q  <= 1'b0;
      frame_width_q <= srd_pkg::WIDTH_RESET;
    end else if (cfg_we_i) begin
      unique case (srd_pkg::cfg_reg_e'(cfg_index_i))
        srd_pkg::REG_FRAME_MODE:  frame_mode_q  <= cfg_wdata_i[0];
        srd_pkg::REG_FRAME_WIDTH: frame_width_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Front end -> queue -> back end.
  logic          push;
  logic          full;
  logic          pop;
  logic          head_valid;
  srd_pkg::job_t push_job;
  srd_pkg::job_t head_job;

  srd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_i          (in_i),
    .frame_mode_i  (frame_mode_q),
    .frame_width_i (frame_width_q),
    .full_i        (full),
    .push_o        (push),
    .job_o         (push_job)
  );

  srd_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_job_i   (push_job),
    .pop_i        (pop),
    .full_o       (full),
    .head_valid_o (head_valid),
    .head_o       (head_job)
  );

  srd_back #(
    .PALETTE_DEPTH (PALETTE_DEPTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head_job),
    .pop_o        (pop),
    .out_o        (out_o)
  );

  // A run never reaches past the widest supported row.
  a_run_in_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> ({1'b0, out_o.start_column} + {1'b0, out_o.run_length})
                    <= {1'b0, srd_pkg::WIDTH_CAP})
    else $error("run extends past the maximum width");

  // End-of-row padding fills exactly the room left, so it is never clipped.
  a_pad_not_clipped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.end_of_row |-> !out_o.overflow)
    else $error("end-of-row padding flagged as overflow");

  // Transparent runs carry no color.
  a_transparent_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.alpha == '0) |->
      (out_o.red == '0) && (out_o.green == '0) && (out_o.blue == '0))
    else $error("transparent run with nonzero color");

  // The front end never pushes into a full queue.
  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !push)
    else $error("job pushed into full queue");

endmodule
